// File: rtl/core/sorted_min_priority_queue_core_assert.svh
// Assertion macros for the sorted min priority queue core.
// The macros sample on clock and stay quiet while reset is high.
`ifndef SORTED_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication.
`define SMPQ_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SMPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/smpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smpq_pkg;

   localparam int DEPTH       = 8;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int WORD_W      = 32;
   localparam int COUNT_OUT_W = 7;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [CNT_W-1:0]         count_type;
   typedef logic [COUNT_OUT_W-1:0]   count_out_type;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture the incoming request
      logic exec;   // apply the captured request and register the response
   } cmd_type;

endpackage

`default_nettype wire

// File: rtl/core/smpq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module smpq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output smpq_pkg::cmd_type     cmd
);
   import smpq_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_EXEC: begin
            cmd.exec = slot_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Hold the response until taken; a new one lands as the old one leaves.
   always_comb begin
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/core/smpq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module smpq_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire smpq_pkg::cmd_type      cmd,
   input  wire smpq_pkg::op_type       req_op,
   input  wire smpq_pkg::word_type     req_value,
   output smpq_pkg::status_type        rsp_status,
   output smpq_pkg::word_type          rsp_removed_value,
   output smpq_pkg::count_out_type     rsp_count
);
   import smpq_pkg::*;

   op_type        op_ff;
   op_type        op_in;
   word_type      value_ff;
   word_type      value_in;
   count_type     count_ff;
   count_type     count_in;
   word_type      store_ff [DEPTH];
   word_type      store_in [DEPTH];
   logic [DEPTH-1:0] keep;
   logic          is_full;
   logic          is_empty;
   logic          do_insert;
   logic          do_remove;
   status_type    status_in;
   word_type      removed_in;
   status_type    rsp_status_ff;
   word_type      rsp_removed_ff;
   count_out_type rsp_count_ff;

   assign op_in    = cmd.load ? req_op    : op_ff;
   assign value_in = cmd.load ? req_value : value_ff;

   assign is_full   = (count_ff == count_type'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign do_insert = cmd.exec && (op_ff == OP_INSERT) && !is_full;
   assign do_remove = cmd.exec && (op_ff == OP_REMOVE) && !is_empty;

   // Compare-shift cells: an entry stays if valid and not above the new word.
   genvar g;
   for (g = 0; g < DEPTH; g++) begin : g_cell
      word_type ins_val;
      word_type rem_val;

      assign keep[g] = (count_type'(g) < count_ff) && (store_ff[g] <= value_ff);

      if (g == 0) begin : g_first
         assign ins_val = keep[g] ? store_ff[g] : value_ff;
      end else begin : g_rest
         assign ins_val = keep[g]   ? store_ff[g] :
                          keep[g-1] ? value_ff    : store_ff[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign rem_val = store_ff[g];
      end else begin : g_inner
         assign rem_val = store_ff[g+1];
      end

      assign store_in[g] = do_insert ? ins_val :
                           do_remove ? rem_val : store_ff[g];
   end

   always_comb begin
      priority if (do_insert) begin
         count_in = count_ff + count_type'(1);
      end else if (do_remove) begin
         count_in = count_ff - count_type'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      status_in  = ST_OK;
      removed_in = '0;
      unique case (op_ff)
         OP_INSERT: begin
            if (is_full) begin
               status_in = ST_FULL;
            end
         end
         OP_REMOVE: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               removed_in = store_ff[0];
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      value_ff <= value_in;
      for (int i = 0; i < DEPTH; i++) begin
         store_ff[i] <= store_in[i];
      end
      if (cmd.exec) begin
         rsp_status_ff  <= status_in;
         rsp_removed_ff <= removed_in;
         rsp_count_ff   <= count_out_type'(count_in);
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_count         = rsp_count_ff;

endmodule

`default_nettype wire

// File: rtl/core/sorted_min_priority_queue_core.sv
// A request is captured on accept; in EXEC, once the response slot is free, all cells
// compare and shift together and the response is registered.
// One request is in flight at a time; the response register lets the next request
// be accepted while the previous response still waits on rsp_tready.
// Reset (synchronous, active high) empties the queue; stored words are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_min_priority_queue_core_assert.svh"

module sorted_min_priority_queue_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,    // [31:0] value
   input  wire logic [0:0]  req_tuser,    // [0] op (0 insert, 1 remove smallest)
   // Response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,    // [31:0] removed_value, [38:32] count, [39] zero
   output logic [1:0]       rsp_tuser     // [1:0] status (0 ok, 1 full, 2 empty)
);
   import smpq_pkg::*;

   cmd_type       cmd;
   op_type        req_op;
   word_type      req_value;
   status_type    rsp_status;
   word_type      rsp_removed_value;
   count_out_type rsp_count;

   // Unpack the request: op rides in tuser, the word in tdata.
   assign req_op    = op_type'(req_tuser[0]);
   assign req_value = word_type'(req_tdata);

   // Controller: accept in IDLE, apply in EXEC once the response slot is free.
   smpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Datapath: sorted store of compare-shift cells, entry count and response register.
   smpq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_op            (req_op),
      .req_value         (req_value),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_count         (rsp_count)
   );

   // Pack the response: status in tuser, removed word and count in tdata.
   assign rsp_tuser = rsp_status;
   assign rsp_tdata = {1'b0, rsp_count, rsp_removed_value};

   // A full report only comes with the store at capacity.
   `SMPQ_ASSERT_IMPL(a_full_at_depth, rsp_tvalid && (rsp_status == ST_FULL),
      rsp_count == count_out_type'(DEPTH), "full status with count below depth")

   // An empty report carries a zero word and a zero count.
   `SMPQ_ASSERT_IMPL(a_empty_zero, rsp_tvalid && (rsp_status == ST_EMPTY),
      (rsp_count == '0) && (rsp_removed_value == '0), "empty status with data")

   // The count never exceeds the store depth.
   `SMPQ_ASSERT_IMPL(a_count_bound, rsp_tvalid,
      rsp_count <= count_out_type'(DEPTH), "count above depth")

   // An accepted request drops req_tready in the cycle after the accept.
   `SMPQ_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready,
      !req_tready, "request accepted back to back")

endmodule

`default_nettype wire

// File: verif/tb_sorted_min_priority_queue_core.sv
`timescale 1ns / 1ps

module tb_sorted_min_priority_queue_core;
   import smpq_pkg::*;

   localparam int            RANDOM_ITEMS = 650;
   localparam int            DIRECTED_N   = 21;
   localparam int            LONG_HOLD    = 60;
   localparam word_type      WORD_MAX     = 32'sh7FFF_FFFF;
   localparam word_type      WORD_MIN     = 32'sh8000_0000;

   typedef struct {
      status_type    status;
      word_type      removed;
      count_out_type count;
   } queue_result_t;

   // A request row: the result is typed in only when pinned is set.
   typedef struct {
      op_type        op;
      word_type      value;
      bit            pinned;
      queue_result_t res;
   } stim_row_t;

   typedef struct {
      bit            pinned;
      queue_result_t res;
   } pin_entry_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // Shadow copy of the queue, advanced on every accepted request.
   word_type      shadow_words [DEPTH];
   int            shadow_count = 0;
   queue_result_t expected_results [$];
   pin_entry_t    pending_pins [$];

   int error_count    = 0;
   int responses_seen = 0;
   int insert_total   = 0;
   int remove_total   = 0;
   int full_hits      = 0;
   int empty_hits     = 0;
   int peak_level     = 0;

   // Directed part: empty remove, extremes, equal words, fill to full,
   // insert on full, then drain in sorted order past empty.
   stim_row_t directed_rows [DIRECTED_N] = '{
      '{OP_REMOVE, 32'sd0,    1'b1, '{ST_EMPTY, 32'sd0,  7'd0}},
      '{OP_INSERT, 32'sd5,    1'b1, '{ST_OK,    32'sd0,  7'd1}},
      '{OP_INSERT, WORD_MAX,  1'b1, '{ST_OK,    32'sd0,  7'd2}},
      '{OP_INSERT, WORD_MIN,  1'b1, '{ST_OK,    32'sd0,  7'd3}},
      '{OP_INSERT, 32'sd5,    1'b1, '{ST_OK,    32'sd0,  7'd4}},
      '{OP_INSERT, -32'sd1,   1'b1, '{ST_OK,    32'sd0,  7'd5}},
      '{OP_INSERT, 32'sd0,    1'b1, '{ST_OK,    32'sd0,  7'd6}},
      '{OP_INSERT, 32'sd5,    1'b1, '{ST_OK,    32'sd0,  7'd7}},
      '{OP_INSERT, 32'sd3,    1'b1, '{ST_OK,    32'sd0,  7'd8}},
      '{OP_INSERT, 32'sd100,  1'b1, '{ST_FULL,  32'sd0,  7'd8}},
      '{OP_REMOVE, -32'sd7,   1'b1, '{ST_OK,    WORD_MIN, 7'd7}},
      '{OP_REMOVE, 32'sd0,    1'b0, '{ST_OK,    32'sd0,  7'd0}},
      '{OP_REMOVE, 32'sd0,    1'b0, '{ST_OK,    32'sd0,  7'd0}},
      '{OP_REMOVE, 32'sd0,    1'b0, '{ST_OK,    32'sd0,  7'd0}},
      '{OP_REMOVE, 32'sd0,    1'b0, '{ST_OK,    32'sd0,  7'd0}},
      '{OP_REMOVE, 32'sd0,    1'b0, '{ST_OK,    32'sd0,  7'd0}},
      '{OP_REMOVE, 32'sd0,    1'b0, '{ST_OK,    32'sd0,  7'd0}},
      '{OP_REMOVE, WORD_MAX,  1'b0, '{ST_OK,    32'sd0,  7'd0}},
      '{OP_REMOVE, WORD_MIN,  1'b1, '{ST_EMPTY, 32'sd0,  7'd0}},
      '{OP_INSERT, WORD_MAX,  1'b0, '{ST_OK,    32'sd0,  7'd0}},
      '{OP_REMOVE, 32'sd0,    1'b0, '{ST_OK,    32'sd0,  7'd0}}
   };

   sorted_min_priority_queue_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [31:0] value
      .req_tuser  (req_tuser),    // [0] op
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [31:0] removed_value, [38:32] count, [39] zero
      .rsp_tuser  (rsp_tuser)     // [1:0] status
   );

   always #10 clock = ~clock;

   // Apply one request to the shadow queue and return the result it must produce.
   function automatic queue_result_t queue_step(input op_type op, input word_type value);
      queue_result_t res;
      int            pos;
      res = '{ST_OK, 32'sd0, 7'd0};
      if (op == OP_INSERT) begin
         if (shadow_count >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            // Shift larger words up; equal words stay ahead of the new one.
            pos = shadow_count;
            while (pos > 0 && shadow_words[pos-1] > value) begin
               shadow_words[pos] = shadow_words[pos-1];
               pos--;
            end
            shadow_words[pos] = value;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.removed = shadow_words[0];
            for (int i = 1; i < shadow_count; i++)
               shadow_words[i-1] = shadow_words[i];
            shadow_count--;
         end
      end
      res.count = count_out_type'(shadow_count);
      return res;
   endfunction

   // Offer one request, hold it until accepted, then idle at random unless calm.
   task automatic offer_request(input op_type op, input word_type value, input bit pinned,
                                input queue_result_t res, input bit calm);
      pending_pins.push_back('{pinned, res});
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      if (!calm) begin
         while ($urandom_range(99) < 12) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // Sender: reset, directed table, then random phases of filling and draining.
   initial begin
      op_type        op;
      word_type      value;
      int            bias;
      int            insert_pct;
      queue_result_t blank;
      blank = '{ST_OK, 32'sd0, 7'd0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_N; r++)
         offer_request(directed_rows[r].op, directed_rows[r].value, directed_rows[r].pinned,
                       directed_rows[r].res, 1'b0);

      bias = 2;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Switch between fill-heavy, drain-heavy and balanced phases.
         if (n % 32 == 0)
            bias = $urandom_range(2);
         insert_pct = (bias == 0) ? 80 : (bias == 1) ? 20 : 50;
         op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
         case ($urandom_range(7))
            0, 1: value = word_type'(int'($urandom_range(8)) - 4);   // force duplicates
            2: begin
               case ($urandom_range(3))
                  0: value = WORD_MIN;
                  1: value = WORD_MAX;
                  2: value = 32'sd0;
                  default: value = -32'sd1;
               endcase
            end
            default: value = word_type'($urandom);
         endcase

         // Wait once for all outstanding responses before going on.
         if (n == 300) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (expected_results.size() != 0) @(posedge clock);
         end
         offer_request(op, value, 1'b0, blank, n >= 420 && n < 520);
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d requests: %0d inserts, %0d removes; %0d full and %0d empty rejects",
               insert_total + remove_total, insert_total, remove_total, full_hits, empty_hits);
      $display("Peak occupancy %0d of %0d, %0d mismatches", peak_level, DEPTH, error_count);
      if (error_count == 0) begin
         $display("tb_sorted_min_priority_queue_core passed");
      end else begin
         $display("tb_sorted_min_priority_queue_core failed");
      end
      $finish;
   end

   // Receiver: random stalls, one long hold-off to back up the request side,
   // and a stretch with no stalls at all.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && responses_seen >= 150) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            if (responses_seen >= 440 && responses_seen < 540)
               rsp_tready <= 1'b1;
            else
               rsp_tready <= ($urandom_range(99) >= 12);
            @(posedge clock);
         end
      end
   end

   // Check responses against the oldest expectation, then predict new requests.
   always @(posedge clock) begin
      queue_result_t want;
      queue_result_t got;
      pin_entry_t    pin;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            responses_seen++;
            got.status  = status_type'(rsp_tuser);
            got.removed = word_type'(rsp_tdata[31:0]);
            got.count   = rsp_tdata[38:32];
            if (expected_results.size() == 0) begin
               $display("%0t: response with none expected: status %0d removed %0d count %0d",
                        $time, got.status, got.removed, got.count);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_tuser);
                  error_count++;
               end
               if (got.removed !== want.removed) begin
                  $display("%0t: removed_value expected %0d actual %0d",
                           $time, want.removed, got.removed);
                  error_count++;
               end
               if (got.count !== want.count) begin
                  $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
                  error_count++;
               end
               if (rsp_tdata[39] !== 1'b0) begin
                  $display("%0t: pad bit expected 0 actual %b", $time, rsp_tdata[39]);
                  error_count++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            want = queue_step(op_type'(req_tuser), word_type'(req_tdata));
            if (pending_pins.size() != 0) begin
               pin = pending_pins.pop_front();
               // Typed rows take the literal result; the shadow still advances.
               if (pin.pinned)
                  want = pin.res;
            end
            expected_results.push_back(want);
            if (op_type'(req_tuser) == OP_INSERT) insert_total++;
            else                                  remove_total++;
            if (want.status == ST_FULL)  full_hits++;
            if (want.status == ST_EMPTY) empty_hits++;
            if (shadow_count > peak_level) peak_level = shadow_count;
         end
      end
   end

   // Run limit.
   initial begin
      #5000000;
      $display("tb_sorted_min_priority_queue_core failed");
      $finish;
   end

endmodule

// File: sorted_min_priority_queue_core.f
+incdir+rtl/core
rtl/core/smpq_pkg.sv
rtl/core/smpq_ctrl.sv
rtl/core/smpq_datapath.sv
rtl/core/sorted_min_priority_queue_core.sv
verif/tb_sorted_min_priority_queue_core.sv
